[sv/ste_pkg.sv]
// Shared types and constants for the subscriber table with expiry.
// Holds the controller state encoding and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ste_pkg;

    localparam int ADDR_W    = 32;
    localparam int PORT_W    = 16;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 16;
    localparam int SLOT_W    = 2;

    localparam logic KIND_TOUCH = 1'b0;
    localparam logic KIND_SEND  = 1'b1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOUCH_SCAN,
        ST_TOUCH_WRITE,
        ST_SEND_SCAN,
        ST_SEND_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic touch_eval;
        logic touch_commit;
        logic send_eval;
        logic emit_load;
        logic idx_inc;
        logic idx_target;
        logic idx_clear;
    } cmd_t;

    typedef struct packed {
        logic touch_hit;
        logic at_last;
        logic list_none;
        logic list_cur;
        logic list_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[sv/ste_ctrl.sv]
// Controller state machine for the subscriber table with expiry.
// Depends on ste_pkg for the state type and the command and status structs.
`default_nettype none

module ste_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_kind,
    output logic                  s_ready,
    input  ste_pkg::status_t      status,
    output ste_pkg::cmd_t         cmd
);

    ste_pkg::state_t state_reg;
    ste_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ste_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ste_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_kind == ste_pkg::KIND_SEND) ? ste_pkg::ST_SEND_SCAN
                                                                : ste_pkg::ST_TOUCH_SCAN;
                end
            end
            ste_pkg::ST_TOUCH_SCAN: begin
                if (status.touch_hit || status.at_last) begin
                    state_next = ste_pkg::ST_TOUCH_WRITE;
                end
            end
            ste_pkg::ST_TOUCH_WRITE: begin
                if (status.out_free) begin
                    state_next = ste_pkg::ST_IDLE;
                end
            end
            ste_pkg::ST_SEND_SCAN: begin
                if (status.at_last) begin
                    state_next = ste_pkg::ST_SEND_EMIT;
                end
            end
            ste_pkg::ST_SEND_EMIT: begin
                if (status.list_none) begin
                    state_next = ste_pkg::ST_IDLE;
                end else if (status.list_cur && status.out_free && status.list_last) begin
                    state_next = ste_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ste_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ste_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.capture   = s_valid;
                cmd.idx_clear = s_valid;
            end
            ste_pkg::ST_TOUCH_SCAN: begin
                cmd.touch_eval = 1'b1;
                if (!status.touch_hit) begin
                    cmd.idx_target = status.at_last;
                    cmd.idx_inc    = !status.at_last;
                end
            end
            ste_pkg::ST_TOUCH_WRITE: begin
                cmd.touch_commit = status.out_free;
            end
            ste_pkg::ST_SEND_SCAN: begin
                cmd.send_eval = 1'b1;
                cmd.idx_clear = status.at_last;
                cmd.idx_inc   = !status.at_last;
            end
            ste_pkg::ST_SEND_EMIT: begin
                if (!status.list_none) begin
                    if (status.list_cur) begin
                        cmd.emit_load = status.out_free;
                        cmd.idx_inc   = status.out_free && !status.list_last;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/ste_datapath.sv]
// Datapath for the subscriber table with expiry: slot storage, slot walker, output register.
// Depends on ste_pkg for widths, constants and the command and status structs.
`default_nettype none

module ste_datapath #(
    parameter int SLOTS = 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  ste_pkg::cmd_t                           cmd,
    output ste_pkg::status_t                        status,
    input  wire logic [ste_pkg::ADDR_W-1:0]         s_client_addr,
    input  wire logic [ste_pkg::PORT_W-1:0]         s_client_port,
    input  wire logic [ste_pkg::TIME_W-1:0]         s_now_sec,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ste_pkg::TIMEOUT_W-1:0]      cfg_wr_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [ste_pkg::SLOT_W-1:0]              m_slot,
    output logic                                    m_new_client,
    output logic                                    m_expired,
    output logic [ste_pkg::ADDR_W-1:0]              m_dest_addr,
    output logic [ste_pkg::PORT_W-1:0]              m_dest_port,
    output logic                                    m_occupied,
    output logic                                    m_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // Captured input word. The kind bit is only steered by the controller.
    logic [ste_pkg::ADDR_W-1:0]    caddr_reg;
    logic [ste_pkg::PORT_W-1:0]    cport_reg;
    logic [ste_pkg::TIME_W-1:0]    now_reg;
    logic [ste_pkg::TIMEOUT_W-1:0] timeout_reg;

    // Slot table.
    logic [SLOTS-1:0]              in_use_reg;
    logic [ste_pkg::ADDR_W-1:0]    slot_addr_reg [SLOTS];
    logic [ste_pkg::PORT_W-1:0]    slot_port_reg [SLOTS];
    logic [ste_pkg::TIME_W-1:0]    slot_seen_reg [SLOTS];

    // Walker and search state.
    logic [IDX_W-1:0]              idx_reg;
    logic                          free_found_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic [IDX_W-1:0]              oldest_idx_reg;
    logic [ste_pkg::TIME_W-1:0]    oldest_time_reg;
    logic [SLOTS-1:0]              list_reg;

    // Output register.
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [ste_pkg::SLOT_W-1:0]    m_slot_reg;
    logic                          m_new_client_reg;
    logic                          m_expired_reg;
    logic [ste_pkg::ADDR_W-1:0]    m_dest_addr_reg;
    logic [ste_pkg::PORT_W-1:0]    m_dest_port_reg;
    logic                          m_occupied_reg;
    logic                          m_last_reg;

    logic                          cur_in_use;
    logic [ste_pkg::ADDR_W-1:0]    cur_addr;
    logic [ste_pkg::PORT_W-1:0]    cur_port;
    logic [ste_pkg::TIME_W-1:0]    cur_seen;
    logic [ste_pkg::TIME_W-1:0]    age;
    logic                          too_old;
    logic                          free_found_next;
    logic [IDX_W-1:0]              free_idx_next;
    logic                          older;
    logic [IDX_W-1:0]              oldest_idx_next;
    logic [IDX_W-1:0]              target;
    logic                          later_listed;
    logic                          out_free;

    assign cur_in_use = in_use_reg[idx_reg];
    assign cur_addr   = slot_addr_reg[idx_reg];
    assign cur_port   = slot_port_reg[idx_reg];
    assign cur_seen   = slot_seen_reg[idx_reg];

    // Age wraps modulo 2^32; strictly older than the timeout expires.
    assign age     = now_reg - cur_seen;
    assign too_old = age > ste_pkg::TIME_W'(timeout_reg);

    // Running lowest-free and stalest-slot search, one slot per cycle.
    assign free_found_next = free_found_reg || !cur_in_use;
    assign free_idx_next   = (!free_found_reg && !cur_in_use) ? idx_reg : free_idx_reg;
    assign older           = (idx_reg == '0) || (cur_seen < oldest_time_reg);
    assign oldest_idx_next = older ? idx_reg : oldest_idx_reg;
    assign target          = free_found_next ? free_idx_next : oldest_idx_next;

    always_comb begin
        later_listed = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (list_reg[j] && (IDX_W'(j) > idx_reg)) begin
                later_listed = 1'b1;
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    assign status.touch_hit = cur_in_use && (cur_addr == caddr_reg) && (cur_port == cport_reg);
    assign status.at_last   = (idx_reg == IDX_LAST);
    assign status.list_none = (list_reg == '0);
    assign status.list_cur  = list_reg[idx_reg];
    assign status.list_last = !later_listed;
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ste_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            caddr_reg <= s_client_addr;
            cport_reg <= s_client_port;
            now_reg   <= s_now_sec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clear) begin
            idx_reg <= '0;
        end else if (cmd.idx_target) begin
            idx_reg <= target;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_found_reg <= 1'b0;
            list_reg       <= '0;
        end else begin
            if (cmd.capture) begin
                free_found_reg <= 1'b0;
                list_reg       <= '0;
            end
            if (cmd.touch_eval) begin
                free_found_reg <= free_found_next;
            end
            if (cmd.send_eval) begin
                list_reg[idx_reg] <= cur_in_use;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.touch_eval) begin
            free_idx_reg   <= free_idx_next;
            oldest_idx_reg <= oldest_idx_next;
            if (older) begin
                oldest_time_reg <= cur_seen;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (cmd.touch_commit) begin
            in_use_reg[idx_reg] <= 1'b1;
        end else if (cmd.send_eval && cur_in_use && too_old) begin
            in_use_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.touch_commit) begin
            slot_addr_reg[idx_reg] <= caddr_reg;
            slot_port_reg[idx_reg] <= cport_reg;
            slot_seen_reg[idx_reg] <= now_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.touch_commit || cmd.emit_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // A slot that expired during the scan has already been freed, so its
    // in-use bit being clear while it is listed marks it as expired.
    always_ff @(posedge aclk) begin
        if (cmd.touch_commit) begin
            m_slot_reg       <= ste_pkg::SLOT_W'(idx_reg);
            m_new_client_reg <= !cur_in_use || (cur_addr != caddr_reg);
            m_expired_reg    <= 1'b0;
            m_dest_addr_reg  <= caddr_reg;
            m_dest_port_reg  <= cport_reg;
            m_occupied_reg   <= 1'b1;
            m_last_reg       <= 1'b1;
        end else if (cmd.emit_load) begin
            m_slot_reg       <= ste_pkg::SLOT_W'(idx_reg);
            m_new_client_reg <= 1'b0;
            m_expired_reg    <= !cur_in_use;
            m_dest_addr_reg  <= cur_addr;
            m_dest_port_reg  <= cur_port;
            m_occupied_reg   <= |in_use_reg;
            m_last_reg       <= !later_listed;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot       = m_slot_reg;
    assign m_new_client = m_new_client_reg;
    assign m_expired    = m_expired_reg;
    assign m_dest_addr  = m_dest_addr_reg;
    assign m_dest_port  = m_dest_port_reg;
    assign m_occupied   = m_occupied_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

[sv/subscriber_table_with_expiry_unit.sv]
// Touch: an accept state, a scan of the slots (stopping early on a match), then a write state.
// Send: an accept state, a scan of every slot, then a walk that emits one word per in-use
// slot. One item at a time; a result word held back by m_ready stalls the write and walk
// states until it is taken.
// Synchronous active-low reset frees every slot, sets the timeout to 5 and empties the output.
// Top level of the subscriber table with expiry; depends on ste_pkg, ste_ctrl and ste_datapath.
`default_nettype none

module subscriber_table_with_expiry_unit #(
    parameter int SLOTS = 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_kind,
    input  wire logic [ste_pkg::ADDR_W-1:0]         s_client_addr,
    input  wire logic [ste_pkg::PORT_W-1:0]         s_client_port,
    input  wire logic [ste_pkg::TIME_W-1:0]         s_now_sec,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [ste_pkg::SLOT_W-1:0]              m_slot,
    output logic                                    m_new_client,
    output logic                                    m_expired,
    output logic [ste_pkg::ADDR_W-1:0]              m_dest_addr,
    output logic [ste_pkg::PORT_W-1:0]              m_dest_port,
    output logic                                    m_occupied,
    output logic                                    m_last,
    input  wire logic                               cfg_wr_en,
    input  wire logic [ste_pkg::TIMEOUT_W-1:0]      cfg_wr_data
);

    // The controller sequences one input word at a time. A touch walks the
    // slots looking for an exact address and port match while tracking the
    // lowest free slot and the stalest slot; it then writes the chosen slot
    // and loads a single result word. A send first walks the slots once,
    // freeing every slot whose age exceeds the timeout and remembering which
    // slots were in use, then walks them again to emit one word per listed
    // slot. Splitting the send into two passes lets every emitted word carry
    // the occupied flag as it stands after the whole step.

    ste_pkg::cmd_t    cmd;
    ste_pkg::status_t status;

    ste_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath owns the slot table, the timeout register and the output
    // register, so a finished word can wait for m_ready while the controller
    // returns to idle and accepts the next input word.
    ste_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_client_addr (s_client_addr),
        .s_client_port (s_client_port),
        .s_now_sec     (s_now_sec),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_new_client  (m_new_client),
        .m_expired     (m_expired),
        .m_dest_addr   (m_dest_addr),
        .m_dest_port   (m_dest_port),
        .m_occupied    (m_occupied),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire

[sv/ste_checker.sv]
// Port-level checks for the subscriber table with expiry, bound to the top level.
// Depends on ste_pkg for field widths.
`default_nettype none

module ste_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [ste_pkg::SLOT_W-1:0]  m_slot,
    input wire logic                        m_new_client,
    input wire logic                        m_expired,
    input wire logic                        m_occupied,
    input wire logic                        m_last
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot) && $stable(m_last))
        else $error("result word changed while stalled");

    // After taking a word the block is busy walking slots.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after an accept");

    // A new client only comes from a touch, which yields a single final word.
    a_new_is_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_client |-> m_last && m_occupied && !m_expired)
        else $error("new-client word with send flags");

    // A listed slot that stays in use keeps the table occupied.
    a_idle_means_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_occupied |-> m_expired)
        else $error("empty table reported a live slot");

endmodule

bind subscriber_table_with_expiry_unit ste_checker u_ste_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_slot       (m_slot),
    .m_new_client (m_new_client),
    .m_expired    (m_expired),
    .m_occupied   (m_occupied),
    .m_last       (m_last)
);

`default_nettype wire
